// File: sv/drrip_pkg.sv
// shared constants, codes and sequencer state type for the drrip tag store
// no dependencies; used by the channel interfaces, the top level, the checker and the testbench
package drrip_pkg;

  localparam int unsigned ADDR_BITS      = 32;
  localparam int unsigned ROLE_SET_BITS  = 6;
  localparam int unsigned ROLE_KIND_BITS = 2;
  localparam int unsigned WAY_OUT_BITS   = 3;
  localparam int unsigned BIM_BITS       = 8;

  typedef enum logic [0:0] {
    OP_ACCESS = 1'b0,
    OP_ROLE   = 1'b1
  } opcode_e;

  localparam logic [ROLE_KIND_BITS-1:0] ROLE_FOLLOWER = 2'd0;
  localparam logic [ROLE_KIND_BITS-1:0] ROLE_SRRIP    = 2'd1;
  localparam logic [ROLE_KIND_BITS-1:0] ROLE_BRRIP    = 2'd2;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_AGE    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

endpackage

// File: sv/drrip_in_if.sv
// input channel: valid/ready handshake carrying one request word
// depends on drrip_pkg
interface drrip_in_if;
  import drrip_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [ADDR_BITS-1:0]      address;
  logic [ROLE_SET_BITS-1:0]  role_set;
  logic [ROLE_KIND_BITS-1:0] role_kind;

  modport source (output valid, opcode, address, role_set, role_kind, input ready);
  modport sink   (input valid, opcode, address, role_set, role_kind, output ready);
endinterface

// File: sv/drrip_out_if.sv
// output channel: valid/ready handshake carrying one result word
// depends on drrip_pkg
interface drrip_out_if;
  import drrip_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [WAY_OUT_BITS-1:0] way;
  logic                    filled_empty;
  logic                    used_bimodal;

  modport source (output valid, hit, way, filled_empty, used_bimodal, input ready);
  modport sink   (input valid, hit, way, filled_empty, used_bimodal, output ready);
endinterface

// File: sv/drrip_cache_replacement.sv
// drrip tag store: top level with way sequencer, policy selector and result register
// depends on drrip_pkg, drrip_in_if, drrip_out_if, drrip_ram
//
// usage
//   in_i carries request words: an access (opcode 0) looks up the address, a role
//   write (opcode 1) sets the sample role of one set. out_o returns one result
//   word per request: hit, way, filled_empty, used_bimodal.
//   a single compare/age unit walks the ways of the addressed set, one way per
//   cycle, through the line ram read port. a hit ends the scan at its way; a
//   miss scans every way, picks a victim and runs an aging pass, one way per
//   cycle, that stops at an invalid victim and writes every way when a valid
//   line is replaced. a role write goes straight to the result. one request is
//   in flight at a time; the next is taken the cycle after the result is
//   registered. SET_COUNT, WAYS, LINE_BYTES and BIP_PERIOD are powers of two.
//   after reset a clearing pass walks every line and wipes valid bits, roles
//   and bimodal counters; in_i.ready stays low meanwhile.
//   the result register holds a word while out_o.ready is low; a new request is
//   still taken, and its result waits in the sequencer until the register frees.
module drrip_cache_replacement #(
  parameter int unsigned SET_COUNT  = 64,
  parameter int unsigned WAYS       = 8,
  parameter int unsigned LINE_BYTES = 64,
  parameter int unsigned BIP_PERIOD = 32,
  parameter int unsigned PSEL_BITS  = 10,
  parameter int unsigned RRPV_BITS  = 2
) (
  input logic         clk_i,
  input logic         rst_ni,
  drrip_in_if.sink    in_i,
  drrip_out_if.source out_o
);
  import drrip_pkg::*;

  localparam int unsigned OFF_W      = $clog2(LINE_BYTES);
  localparam int unsigned SET_W      = $clog2(SET_COUNT);
  localparam int unsigned WAY_W      = $clog2(WAYS);
  localparam int unsigned TAG_W      = ADDR_BITS - OFF_W - SET_W;
  localparam int unsigned LINE_AW    = SET_W + WAY_W;
  localparam int unsigned LINE_DEPTH = SET_COUNT << WAY_W;
  localparam int unsigned BIP_W      = $clog2(BIP_PERIOD);

  localparam logic [RRPV_BITS-1:0] RRPV_MAX  = {RRPV_BITS{1'b1}};
  localparam logic [RRPV_BITS-1:0] RRPV_LONG = RRPV_MAX - RRPV_BITS'(1);
  localparam logic [PSEL_BITS-1:0] PSEL_MAX  = {PSEL_BITS{1'b1}};
  localparam logic [PSEL_BITS-1:0] PSEL_MID  = {1'b1, {(PSEL_BITS-1){1'b0}}};
  localparam logic [LINE_AW-1:0]   CLR_LAST  = LINE_AW'(LINE_DEPTH - 1);
  localparam logic [WAY_W-1:0]     WAY_LAST  = WAY_W'(WAYS - 1);

  state_e state_q, state_d;

  logic [LINE_AW-1:0]   clr_q, clr_d;
  logic [SET_W-1:0]     set_q, set_d;
  logic [TAG_W-1:0]     tag_q, tag_d;
  logic [WAY_W-1:0]     way_q, way_d;
  logic                 inv_found_q, inv_found_d;
  logic [WAY_W-1:0]     inv_way_q, inv_way_d;
  logic [RRPV_BITS-1:0] top_q, top_d;
  logic [WAY_W-1:0]     top_way_q, top_way_d;
  logic [RRPV_BITS-1:0] rr_q [WAYS];
  logic [RRPV_BITS-1:0] rr_d [WAYS];
  logic [WAY_W-1:0]     victim_q, victim_d;
  logic [RRPV_BITS-1:0] ins_q, ins_d;
  logic [RRPV_BITS-1:0] add_q, add_d;
  logic [PSEL_BITS-1:0] psel_q, psel_d;

  logic                 res_hit_q, res_hit_d;
  logic [WAY_W-1:0]     res_way_q, res_way_d;
  logic                 res_empty_q, res_empty_d;
  logic                 res_bim_q, res_bim_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q, out_hit_d;
  logic [WAY_OUT_BITS-1:0] out_way_q, out_way_d;
  logic                    out_empty_q, out_empty_d;
  logic                    out_bim_q, out_bim_d;

  // ram ports
  logic                      tag_we;
  logic [LINE_AW-1:0]        tag_waddr, line_raddr;
  logic [TAG_W:0]            tag_wdata, tag_rdata;
  logic                      rrpv_we;
  logic [LINE_AW-1:0]        rrpv_waddr;
  logic [RRPV_BITS-1:0]      rrpv_wdata, rrpv_rdata;
  logic                      role_we;
  logic [SET_W-1:0]          role_waddr, set_raddr;
  logic [ROLE_KIND_BITS-1:0] role_wdata, role_rdata;
  logic                      bim_we;
  logic [SET_W-1:0]          bim_waddr;
  logic [BIM_BITS-1:0]       bim_wdata, bim_rdata;

  // request decode
  logic                     in_fire;
  logic [SET_W-1:0]         in_set;
  logic [TAG_W-1:0]         in_tag;
  logic [SET_W+ROLE_SET_BITS-1:0] role_set_ext;
  logic                     role_in_range;
  logic [WAY_W+WAY_OUT_BITS-1:0]  way_ext;

  // shared way unit
  logic                 cur_valid;
  logic [TAG_W-1:0]     cur_tag;
  logic                 cur_match;
  logic [RRPV_BITS:0]   age_sum;
  logic                 brrip;
  logic [BIM_BITS-1:0]  bim_next;

  assign in_fire       = in_i.valid && in_i.ready;
  assign in_set        = in_i.address[OFF_W +: SET_W];
  assign in_tag        = in_i.address[ADDR_BITS-1 -: TAG_W];
  assign role_set_ext  = {{SET_W{1'b0}}, in_i.role_set};
  assign role_in_range = role_set_ext < (SET_W + ROLE_SET_BITS)'(SET_COUNT);
  assign way_ext       = {{WAY_OUT_BITS{1'b0}}, res_way_q};

  assign cur_valid = tag_rdata[TAG_W];
  assign cur_tag   = tag_rdata[TAG_W-1:0];
  assign cur_match = cur_valid && (cur_tag == tag_q);
  assign age_sum   = {1'b0, rr_q[way_q]} + {1'b0, add_q};
  assign bim_next  = bim_rdata + BIM_BITS'(1);

  assign in_i.ready = (state_q == ST_IDLE);

  assign out_o.valid        = out_valid_q;
  assign out_o.hit          = out_hit_q;
  assign out_o.way          = out_way_q;
  assign out_o.filled_empty = out_empty_q;
  assign out_o.used_bimodal = out_bim_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    set_d       = set_q;
    tag_d       = tag_q;
    way_d       = way_q;
    inv_found_d = inv_found_q;
    inv_way_d   = inv_way_q;
    top_d       = top_q;
    top_way_d   = top_way_q;
    rr_d        = rr_q;
    victim_d    = victim_q;
    ins_d       = ins_q;
    add_d       = add_q;
    psel_d      = psel_q;
    res_hit_d   = res_hit_q;
    res_way_d   = res_way_q;
    res_empty_d = res_empty_q;
    res_bim_d   = res_bim_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_hit_d   = out_hit_q;
    out_way_d   = out_way_q;
    out_empty_d = out_empty_q;
    out_bim_d   = out_bim_q;
    brrip       = 1'b0;

    tag_we     = 1'b0;
    tag_waddr  = {set_q, victim_q};
    tag_wdata  = {1'b1, tag_q};
    line_raddr = {set_q, way_q + WAY_W'(1)};
    rrpv_we    = 1'b0;
    rrpv_waddr = {set_q, way_q};
    rrpv_wdata = '0;
    role_we    = 1'b0;
    role_waddr = role_set_ext[SET_W-1:0];
    role_wdata = in_i.role_kind;
    set_raddr  = set_q;
    bim_we     = 1'b0;
    bim_waddr  = set_q;
    bim_wdata  = bim_next;

    case (state_q)
      ST_CLEAR: begin
        tag_we     = 1'b1;
        tag_waddr  = clr_q;
        tag_wdata  = '0;
        role_we    = 1'b1;
        role_waddr = clr_q[LINE_AW-1 -: SET_W];
        role_wdata = ROLE_FOLLOWER;
        bim_we     = 1'b1;
        bim_waddr  = clr_q[LINE_AW-1 -: SET_W];
        bim_wdata  = '0;
        clr_d      = clr_q + LINE_AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        line_raddr = {in_set, {WAY_W{1'b0}}};
        set_raddr  = in_set;
        if (in_fire) begin
          res_hit_d   = 1'b0;
          res_way_d   = '0;
          res_empty_d = 1'b0;
          res_bim_d   = 1'b0;
          if (in_i.opcode == OP_ROLE) begin
            role_we = role_in_range;
            state_d = ST_DONE;
          end else begin
            set_d       = in_set;
            tag_d       = in_tag;
            way_d       = '0;
            inv_found_d = 1'b0;
            top_d       = '0;
            top_way_d   = '0;
            state_d     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        rr_d[way_q] = rrpv_rdata;
        if (cur_match) begin
          rrpv_we   = 1'b1;
          res_hit_d = 1'b1;
          res_way_d = way_q;
          state_d   = ST_DONE;
        end else begin
          if (!cur_valid && !inv_found_q) begin
            inv_found_d = 1'b1;
            inv_way_d   = way_q;
          end
          if (rrpv_rdata > top_q) begin
            top_d     = rrpv_rdata;
            top_way_d = way_q;
          end
          way_d = way_q + WAY_W'(1);
          if (way_q == WAY_LAST) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (role_rdata == ROLE_SRRIP && psel_q != PSEL_MAX) begin
          psel_d = psel_q + PSEL_BITS'(1);
        end else if (role_rdata == ROLE_BRRIP && psel_q != '0) begin
          psel_d = psel_q - PSEL_BITS'(1);
        end
        if (role_rdata == ROLE_SRRIP) begin
          brrip = 1'b0;
        end else if (role_rdata == ROLE_BRRIP) begin
          brrip = 1'b1;
        end else begin
          brrip = (psel_d & PSEL_MID) != '0;
        end
        bim_we = brrip;
        if (brrip && bim_next[BIP_W-1:0] != '0) begin
          ins_d = RRPV_MAX;
        end else begin
          ins_d = RRPV_LONG;
        end
        res_bim_d = brrip;
        way_d     = '0;
        add_d     = RRPV_MAX - top_q;
        if (inv_found_q) begin
          victim_d    = inv_way_q;
          res_empty_d = 1'b1;
          state_d     = ST_AGE;
        end else begin
          victim_d = top_way_q;
          state_d  = ST_AGE;
        end
        res_way_d = victim_d;
      end

      ST_AGE: begin
        // victim line is written once here; other ways age only on a full set
        tag_we     = (way_q == victim_q);
        rrpv_we    = (way_q == victim_q) || !res_empty_q;
        rrpv_wdata = (way_q == victim_q) ? ins_q : age_sum[RRPV_BITS-1:0];
        way_d      = way_q + WAY_W'(1);
        if (way_q == WAY_LAST || (res_empty_q && way_q == victim_q)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_way_d   = way_ext[WAY_OUT_BITS-1:0];
          out_empty_d = res_empty_q;
          out_bim_d   = res_bim_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      psel_q      <= PSEL_MID;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      psel_q      <= psel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q       <= set_d;
    tag_q       <= tag_d;
    way_q       <= way_d;
    inv_found_q <= inv_found_d;
    inv_way_q   <= inv_way_d;
    top_q       <= top_d;
    top_way_q   <= top_way_d;
    rr_q        <= rr_d;
    victim_q    <= victim_d;
    ins_q       <= ins_d;
    add_q       <= add_d;
    res_hit_q   <= res_hit_d;
    res_way_q   <= res_way_d;
    res_empty_q <= res_empty_d;
    res_bim_q   <= res_bim_d;
    out_hit_q   <= out_hit_d;
    out_way_q   <= out_way_d;
    out_empty_q <= out_empty_d;
    out_bim_q   <= out_bim_d;
  end

  // line valid and tag
  drrip_ram #(
    .WIDTH (TAG_W + 1),
    .DEPTH (LINE_DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (line_raddr),
    .rdata_o (tag_rdata)
  );

  // line rrpv
  drrip_ram #(
    .WIDTH (RRPV_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_rrpv_ram (
    .clk_i   (clk_i),
    .we_i    (rrpv_we),
    .waddr_i (rrpv_waddr),
    .wdata_i (rrpv_wdata),
    .raddr_i (line_raddr),
    .rdata_o (rrpv_rdata)
  );

  // per set sample role
  drrip_ram #(
    .WIDTH (ROLE_KIND_BITS),
    .DEPTH (SET_COUNT)
  ) u_role_ram (
    .clk_i   (clk_i),
    .we_i    (role_we),
    .waddr_i (role_waddr),
    .wdata_i (role_wdata),
    .raddr_i (set_raddr),
    .rdata_o (role_rdata)
  );

  // per set bimodal insertion count
  drrip_ram #(
    .WIDTH (BIM_BITS),
    .DEPTH (SET_COUNT)
  ) u_bim_ram (
    .clk_i   (clk_i),
    .we_i    (bim_we),
    .waddr_i (bim_waddr),
    .wdata_i (bim_wdata),
    .raddr_i (set_raddr),
    .rdata_o (bim_rdata)
  );

  a_psel_only_on_miss : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (psel_q != $past(psel_q)) |-> ($past(state_q) == ST_DECIDE)
  ) else $error("policy selector moved outside miss handling");

  a_out_from_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE)
  ) else $error("result word raised without a finished request");

  a_tag_write_state : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    tag_we |-> (state_q == ST_CLEAR || state_q == ST_AGE)
  ) else $error("line tag written outside clear or fill");

  a_age_no_wrap : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AGE && !res_empty_q) |-> !age_sum[RRPV_BITS]
  ) else $error("aging overflowed the rrpv range");

  a_clear_ends_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_q == CLR_LAST) |=> (state_q == ST_IDLE)
  ) else $error("clearing pass did not end in idle");

endmodule

// File: sv/drrip_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module drrip_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/drrip_replacement_checker.sv
`timescale 1ns / 1ps
// checker for the drrip tag store: mirrors valid, tag, rrpv, role, selector and bimodal state
// depends on drrip_pkg, drrip_in_if and drrip_out_if
module drrip_replacement_checker (
  input  logic clk_i,
  input  logic rst_ni,
  drrip_in_if  in_i,
  drrip_out_if out_i,
  output int   error_count_o,
  output int   pending_o
);
  import drrip_pkg::*;

  localparam int SET_COUNT   = 64;
  localparam int WAYS        = 8;
  localparam int LINE_BYTES  = 64;
  localparam int BIP_PERIOD  = 32;
  localparam int PSEL_BITS   = 10;
  localparam int RRPV_BITS   = 2;
  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS    = $clog2(SET_COUNT);
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;

  localparam logic [RRPV_BITS-1:0] RRPV_DISTANT = '1;
  localparam logic [RRPV_BITS-1:0] RRPV_LONG    = RRPV_DISTANT - RRPV_BITS'(1);
  localparam logic [PSEL_BITS-1:0] PSEL_TOP     = '1;
  localparam logic [PSEL_BITS-1:0] PSEL_MID     = PSEL_BITS'(1 << (PSEL_BITS - 1));

  typedef struct packed {
    logic                    hit;
    logic [WAY_OUT_BITS-1:0] way;
    logic                    filled_empty;
    logic                    used_bimodal;
  } outcome_t;

  logic                      line_valid [SET_COUNT][WAYS];
  logic [TAG_BITS-1:0]       line_tag   [SET_COUNT][WAYS];
  logic [RRPV_BITS-1:0]      line_rrpv  [SET_COUNT][WAYS];
  logic [ROLE_KIND_BITS-1:0] set_role   [SET_COUNT];
  logic [BIM_BITS-1:0]       bip_count  [SET_COUNT];
  logic [PSEL_BITS-1:0]      psel;
  outcome_t                  outcome_q[$];

  task automatic flag_mismatch(input string what);
    if (error_count_o < 200) begin
      $display("%0t: mismatch, %s", $time, what);
    end
    error_count_o++;
  endtask

  function automatic outcome_t resolve_access(input logic op, input logic [ADDR_BITS-1:0] addr,
                                              input logic [ROLE_SET_BITS-1:0] rset,
                                              input logic [ROLE_KIND_BITS-1:0] rkind);
    outcome_t             res;
    logic [SET_BITS-1:0]  s;
    logic [TAG_BITS-1:0]  t;
    logic [RRPV_BITS-1:0] ins;
    logic [RRPV_BITS-1:0] oldest;
    logic                 bimodal;
    int                   victim;
    res = '0;
    if (op == OP_ROLE) begin
      if (rset < SET_COUNT) set_role[rset] = rkind;
      return res;
    end
    s = addr[OFFSET_BITS +: SET_BITS];
    t = addr[ADDR_BITS-1 -: TAG_BITS];
    for (int w = 0; w < WAYS; w++) begin
      if (line_valid[s][w] && line_tag[s][w] == t) begin
        line_rrpv[s][w] = '0;
        res.hit = 1'b1;
        res.way = w[WAY_OUT_BITS-1:0];
        return res;
      end
    end
    if (set_role[s] == ROLE_SRRIP && psel != PSEL_TOP) psel++;
    else if (set_role[s] == ROLE_BRRIP && psel != '0) psel--;
    if (set_role[s] == ROLE_SRRIP) bimodal = 1'b0;
    else if (set_role[s] == ROLE_BRRIP) bimodal = 1'b1;
    else bimodal = psel[PSEL_BITS-1];
    ins = RRPV_LONG;
    if (bimodal) begin
      bip_count[s]++;
      if ((bip_count[s] % BIP_PERIOD) != 0) ins = RRPV_DISTANT;
    end
    victim = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (victim < 0 && !line_valid[s][w]) victim = w;
    end
    if (victim >= 0) begin
      res.filled_empty = 1'b1;
    end else begin
      // age the whole set until some line sits at distant
      oldest = '0;
      for (int w = 0; w < WAYS; w++) begin
        if (line_rrpv[s][w] > oldest) oldest = line_rrpv[s][w];
      end
      for (int w = 0; w < WAYS; w++) begin
        line_rrpv[s][w] = line_rrpv[s][w] + (RRPV_DISTANT - oldest);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (line_rrpv[s][w] == RRPV_DISTANT) victim = w;
      end
    end
    line_valid[s][victim] = 1'b1;
    line_tag[s][victim]   = t;
    line_rrpv[s][victim]  = ins;
    res.way          = victim[WAY_OUT_BITS-1:0];
    res.used_bimodal = bimodal;
    return res;
  endfunction

  task automatic check_word();
    outcome_t got;
    outcome_t want;
    got.hit          = out_i.hit;
    got.way          = out_i.way;
    got.filled_empty = out_i.filled_empty;
    got.used_bimodal = out_i.used_bimodal;
    if (outcome_q.size() == 0) begin
      flag_mismatch("result word with nothing pending");
    end else begin
      want = outcome_q.pop_front();
      if (got.hit !== want.hit || got.way !== want.way ||
          got.filled_empty !== want.filled_empty || got.used_bimodal !== want.used_bimodal) begin
        flag_mismatch($sformatf("hit %b/%b way %0d/%0d filled_empty %b/%b used_bimodal %b/%b",
                                got.hit, want.hit, got.way, want.way, got.filled_empty,
                                want.filled_empty, got.used_bimodal, want.used_bimodal));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SET_COUNT; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_tag[s][w]   = '0;
          line_rrpv[s][w]  = '0;
        end
        set_role[s]  = ROLE_FOLLOWER;
        bip_count[s] = '0;
      end
      psel = PSEL_MID;
      outcome_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) check_word();
      if (in_i.valid && in_i.ready) begin
        outcome_q.push_back(resolve_access(in_i.opcode, in_i.address, in_i.role_set,
                                           in_i.role_kind));
      end
    end
    pending_o = outcome_q.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// top of the drrip tag store bench: clock, reset, request stimulus and result stalls
// depends on drrip_pkg, both channel interfaces, the checker and drrip_cache_replacement
module testbench;
  import drrip_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int UP_WORDS     = 600;
  localparam int DOWN_WORDS   = 1150;
  localparam int TAIL_WORDS   = 150;
  localparam logic [ROLE_SET_BITS-1:0]  SRRIP_SAMPLE = 6'd1;
  localparam logic [ROLE_SET_BITS-1:0]  BRRIP_SAMPLE = 6'd2;
  localparam logic [ROLE_KIND_BITS-1:0] ROLE_SPARE   = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm   = 1'b0;
  int   cycle_count = 0;
  int   error_count;
  int   pending;
  int   stall_left = 0;

  logic [19:0]              hot_tag [12];
  logic [ROLE_SET_BITS-1:0] hot_set [4];

  drrip_in_if  req_ch ();
  drrip_out_if rsp_ch ();

  drrip_cache_replacement dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  drrip_replacement_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (req_ch),
    .out_i         (rsp_ch),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side stalls in bursts of random length until the calm tail
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic logic [31:0] line_addr(input logic [19:0] t, input logic [5:0] s);
    logic [5:0] off;
    off = 6'($urandom_range(0, 63));
    return {t, s, off};
  endfunction

  task automatic push_word(input opcode_e op, input logic [31:0] addr,
                           input logic [ROLE_SET_BITS-1:0] rset,
                           input logic [ROLE_KIND_BITS-1:0] rkind);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= op;
    req_ch.address   <= addr;
    req_ch.role_set  <= rset;
    req_ch.role_kind <= rkind;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic access(input logic [31:0] addr);
    push_word(OP_ACCESS, addr, ROLE_SET_BITS'($urandom_range(0, 63)),
              ROLE_KIND_BITS'($urandom_range(0, 3)));
  endtask

  // bias_set steers most misses into one sample set to drive the selector to a rail
  task automatic random_word(input logic [ROLE_SET_BITS-1:0] bias_set, input bit biased);
    int pick;
    logic [ROLE_SET_BITS-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < (biased ? 90 : 15)) begin
      s = biased ? bias_set : ($urandom_range(0, 1) ? SRRIP_SAMPLE : BRRIP_SAMPLE);
      access(line_addr(20'($urandom), s));
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 6) access(line_addr(hot_tag[$urandom_range(0, 11)], hot_set[$urandom_range(0, 3)]));
      else if (pick < 8) access($urandom);
      else push_word(OP_ROLE, $urandom, ROLE_SET_BITS'($urandom_range(3, 63)),
                     ROLE_KIND_BITS'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_ACCESS;
    req_ch.address   = '0;
    req_ch.role_set  = '0;
    req_ch.role_kind = ROLE_FOLLOWER;
    rsp_ch.ready     = 1'b0;
    for (int i = 0; i < 12; i++) hot_tag[i] = 20'($urandom);
    hot_set[0] = 6'd0;
    hot_set[1] = 6'd3;
    hot_set[2] = 6'd4;
    hot_set[3] = 6'd63;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // address extremes, miss then hit on the same line
    access(32'h0000_0000);
    access(32'h0000_003F);
    access(32'hFFFF_FFFF);
    access(32'hFFFF_FFC0);
    push_word(OP_ROLE, 32'h0, SRRIP_SAMPLE, ROLE_SRRIP);
    push_word(OP_ROLE, 32'h0, BRRIP_SAMPLE, ROLE_BRRIP);
    push_word(OP_ROLE, 32'h0, 6'd63, ROLE_SPARE);
    push_word(OP_ROLE, 32'h0, 6'd0, ROLE_FOLLOWER);
    // fill one set, then force aging and a replacement
    for (int i = 0; i < 9; i++) access(line_addr({i[3:0], 16'hA5C3}, 6'd3));
    access(line_addr({4'd4, 16'hA5C3}, 6'd3));
    access(line_addr(20'h5A3C7, 6'd3));
    access(line_addr(20'h00000, 6'd63));
    access(line_addr(20'h12345, SRRIP_SAMPLE));
    access(line_addr(20'h6789A, BRRIP_SAMPLE));

    repeat (UP_WORDS) random_word(SRRIP_SAMPLE, 1'b1);
    repeat (DOWN_WORDS) random_word(BRRIP_SAMPLE, 1'b1);
    calm = 1'b1;
    repeat (TAIL_WORDS) random_word(SRRIP_SAMPLE, 1'b0);

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
